FILE: rtl/core/bgu_pkg.sv
package bgu_pkg;

  localparam int FRAC_W = 17;  // Q1.16 fraction, 0..65536 inclusive
  localparam int VAL_W  = 16;  // Q8.8 heights
  localparam int COL_W  = 28;  // row results, 16 fraction bits
  localparam int CF_W   = 32;  // spline coefficients
  localparam int PR_W   = 50;  // coefficient * power products
  localparam int SUM_W  = 52;  // spline sum
  localparam int HV_W   = SUM_W - 25;

  typedef logic [FRAC_W-1:0]        frac_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [COL_W-1:0]  col_t;
  typedef logic signed [CF_W-1:0]   coef_t;
  typedef logic signed [PR_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    frac_t t1;
    frac_t t2;
    frac_t t3;
  } tpow_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    col_t  d;
  } spl_coef_t;

  typedef struct packed {
    prod_t pa;
    prod_t pb;
    prod_t pc;
    col_t  d;
  } spl_prod_t;

  // floor(a*b / 2^16) on fractions
  function automatic frac_t frac_mul(frac_t a, frac_t b);
    logic [2*FRAC_W-1:0] m;
    m = a * b;
    return m[FRAC_W+15:16];
  endfunction

  // Catmull-Rom weights, spline value = (2d + a t + b t^2 + c t^3) / 2
  function automatic spl_coef_t spl_coef(col_t p0, col_t p1, col_t p2, col_t p3);
    spl_coef_t r;
    coef_t q0, q1, q2, q3;
    q0 = CF_W'(p0);
    q1 = CF_W'(p1);
    q2 = CF_W'(p2);
    q3 = CF_W'(p3);
    r.a = q2 - q0;
    r.b = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    r.c = q1 + (q1 <<< 1) - q0 - q2 - (q2 <<< 1) + q3;
    r.d = p1;
    return r;
  endfunction

  function automatic prod_t coef_mul(coef_t k, frac_t t);
    prod_t r;
    r = k * $signed({1'b0, t});
    return r;
  endfunction

  function automatic spl_prod_t spl_mul(spl_coef_t k, tpow_t t);
    spl_prod_t r;
    r.pa = coef_mul(k.a, t.t1);
    r.pb = coef_mul(k.b, t.t2);
    r.pc = coef_mul(k.c, t.t3);
    r.d  = k.d;
    return r;
  endfunction

  function automatic sum_t spl_sum(spl_prod_t p);
    sum_t s;
    s = (SUM_W'(p.d) <<< 17) + SUM_W'(p.pa) + SUM_W'(p.pb) + SUM_W'(p.pc);
    return s;
  endfunction

  // round half up, 9 bits dropped
  function automatic col_t row_round(sum_t s);
    sum_t h;
    h = s + sum_t'(256);
    h = h >>> 9;
    return h[COL_W-1:0];
  endfunction

endpackage

FILE: rtl/core/bicubic_grid_upsampler.sv
// Bicubic grid upsampler. Holds a CONTROL_SIZE x CONTROL_SIZE grid of Q8.8
// control heights and answers fine-grid queries with a separable Catmull-Rom
// interpolation (four row splines, then one column spline), rounded and
// saturated to Q8.8. A word with cmd_i=0 writes one control point (ignored
// when outside the grid) and gives no result; a word with cmd_i=1 gives one
// result on height_o/saturated_o, marked by valid_o for one cycle: valid_o
// rises with the result, both registered in the last pipeline stage. Results
// come out in query order and the receiver cannot stall them. busy stays
// low: one word is taken every cycle, set by the eight-stage arithmetic
// pipeline and by the 16 grid banks that each read one entry per cycle. A
// write is visible to any query accepted in a later cycle. Querying a
// window that holds never-written points gives an undefined height.
module bicubic_grid_upsampler
  import bgu_pkg::*;
#(
  parameter int CONTROL_SIZE = 32,
  parameter int FINE_SIZE    = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cmd_i,
  input  logic [4:0] ctrl_row_i,
  input  logic [4:0] ctrl_col_i,
  input  logic [15:0] ctrl_value_i,
  input  logic [7:0] fine_x_i,
  input  logic [7:0] fine_z_i,
  output logic       valid_o,
  output logic [15:0] height_o,
  output logic       saturated_o
);

  localparam int IW         = $clog2(CONTROL_SIZE);
  localparam int MAP_W      = IW + FRAC_W;
  localparam int BANK_DIM   = (CONTROL_SIZE + 3) / 4;
  localparam int BANK_DEPTH = BANK_DIM * BANK_DIM;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int NSTG       = 8;

  // fine coordinate -> {control index, fraction}, built at elaboration
  typedef logic [MAP_W-1:0] map_tbl_t [256];

  function automatic map_tbl_t build_map();
    map_tbl_t tb;
    int cc, n, i, r, f;
    for (int c = 0; c < 256; c++) begin
      cc = (c > FINE_SIZE - 1) ? FINE_SIZE - 1 : c;
      n  = cc * (CONTROL_SIZE - 3);
      i  = n / (FINE_SIZE - 1);
      r  = n % (FINE_SIZE - 1);
      f  = (r * 65536) / (FINE_SIZE - 1);
      if (i > CONTROL_SIZE - 4) begin
        // last fine point: stay inside the grid with fraction one
        i = CONTROL_SIZE - 4;
        f = 65536;
      end
      tb[c] = {IW'(i), FRAC_W'(f)};
    end
    return tb;
  endfunction

  localparam map_tbl_t MAP_TBL = build_map();

  assign busy = 1'b0;

  logic       word_acc;
  logic [NSTG-1:0] v_q, v_d;
  assign word_acc = start && !busy;
  assign v_d      = {v_q[NSTG-2:0], word_acc && cmd_i};

  // ---- grid write port -------------------------------------------------
  logic          wr_en;
  logic [3:0]    wr_bank;
  logic [AW-1:0] wr_addr;
  assign wr_en   = word_acc && !cmd_i && (32'(ctrl_row_i) < CONTROL_SIZE)
                   && (32'(ctrl_col_i) < CONTROL_SIZE);
  assign wr_bank = {ctrl_row_i[1:0], ctrl_col_i[1:0]};
  assign wr_addr = AW'(32'(ctrl_row_i[4:2]) * BANK_DIM + 32'(ctrl_col_i[4:2]));

  // ---- stage 1: axis mapping ------------------------------------------
  logic [MAP_W-1:0] ent_x, ent_z;
  logic [IW-1:0]    ix1_q, iz1_q;
  frac_t            tx1_q, tz1_q;
  assign ent_x = MAP_TBL[fine_x_i];
  assign ent_z = MAP_TBL[fine_z_i];

  // ---- stage 2: bank reads, squares -----------------------------------
  logic [15:0] bank_q [16];
  logic [1:0]  ix2_q, iz2_q;
  frac_t       tx2_q, txs2_q, tz2_q, tzs2_q;

  for (genvar b = 0; b < 16; b++) begin : g_bank
    localparam logic [1:0] BR = 2'(b / 4);
    localparam logic [1:0] BC = 2'(b % 4);
    logic [15:0]   mem [BANK_DEPTH];
    logic [1:0]    roff, coff;
    logic [IW-1:0] rrow, rcol;
    logic [AW-1:0] rd_addr;
    assign roff    = BR - iz1_q[1:0];
    assign coff    = BC - ix1_q[1:0];
    assign rrow    = iz1_q + IW'(roff);
    assign rcol    = ix1_q + IW'(coff);
    assign rd_addr = AW'((32'(rrow) >> 2) * BANK_DIM + (32'(rcol) >> 2));
    always_ff @(posedge clk_i) begin
      if (wr_en && wr_bank == 4'(b)) begin
        mem[wr_addr] <= ctrl_value_i;
      end
      bank_q[b] <= mem[rd_addr];
    end
  end

  // ---- stage 3: window rotate, row coefficients, cubes -----------------
  col_t      win [16];
  spl_coef_t rcoef_d [4];
  spl_coef_t rcoef_q [4];
  tpow_t     txp3_q;
  tpow_t     tzp_q [3:6];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        win[r*4+c] = COL_W'($signed(bank_q[{2'(iz2_q + 2'(r)), 2'(ix2_q + 2'(c))}]));
      end
      rcoef_d[r] = spl_coef(win[r*4], win[r*4+1], win[r*4+2], win[r*4+3]);
    end
  end

  // ---- stage 4: row products; stage 5: row sums -----------------------
  spl_prod_t rprod_q [4];
  col_t      col_q [4];
  // ---- stage 6: column coefficients; 7: products; 8: output -----------
  spl_coef_t ccoef_q;
  spl_prod_t cprod_q;
  sum_t      csum;
  sum_t      crnd;
  logic signed [HV_W-1:0] hv;
  logic [15:0] height_d;
  logic        sat_d;
  logic [15:0] height_q;
  logic        sat_q;

  always_comb begin
    csum = spl_sum(cprod_q);
    crnd = (csum + sum_t'(1 << 24)) >>> 25;
    hv   = crnd[HV_W-1:0];
    sat_d    = 1'b0;
    height_d = hv[15:0];
    if (hv > HV_W'(32767)) begin
      height_d = 16'h7fff;
      sat_d    = 1'b1;
    end else if (hv < -HV_W'(32768)) begin
      height_d = 16'h8000;
      sat_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1
    ix1_q  <= ent_x[MAP_W-1:FRAC_W];
    tx1_q  <= ent_x[FRAC_W-1:0];
    iz1_q  <= ent_z[MAP_W-1:FRAC_W];
    tz1_q  <= ent_z[FRAC_W-1:0];
    // stage 2
    ix2_q  <= ix1_q[1:0];
    iz2_q  <= iz1_q[1:0];
    tx2_q  <= tx1_q;
    tz2_q  <= tz1_q;
    txs2_q <= frac_mul(tx1_q, tx1_q);
    tzs2_q <= frac_mul(tz1_q, tz1_q);
    // stage 3
    rcoef_q   <= rcoef_d;
    txp3_q    <= '{t1: tx2_q, t2: txs2_q, t3: frac_mul(txs2_q, tx2_q)};
    tzp_q[3]  <= '{t1: tz2_q, t2: tzs2_q, t3: frac_mul(tzs2_q, tz2_q)};
    // stage 4
    for (int r = 0; r < 4; r++) begin
      rprod_q[r] <= spl_mul(rcoef_q[r], txp3_q);
    end
    tzp_q[4] <= tzp_q[3];
    // stage 5
    for (int r = 0; r < 4; r++) begin
      col_q[r] <= row_round(spl_sum(rprod_q[r]));
    end
    tzp_q[5] <= tzp_q[4];
    // stage 6
    ccoef_q  <= spl_coef(col_q[0], col_q[1], col_q[2], col_q[3]);
    tzp_q[6] <= tzp_q[5];
    // stage 7
    cprod_q  <= spl_mul(ccoef_q, tzp_q[6]);
    // stage 8
    height_q <= height_d;
    sat_q    <= sat_d;
  end

  assign valid_o     = v_q[NSTG-1];
  assign height_o    = height_q;
  assign saturated_o = sat_q;

  // ---- checks ---------------------------------------------------------
  a_result_from_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy && cmd_i, NSTG))
    else $error("result without matching query");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cmd_i) |-> ##8 !valid_o)
    else $error("write produced a result");

  a_sat_rails : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturated_o) |-> (height_o == 16'h7fff || height_o == 16'h8000))
    else $error("saturated height off the rails");

endmodule
